>>> hdl/cdc_pkg.sv
// cdc_pkg: shared types, action codes and calendar helpers for the date counter
// no dependencies; used by cdc_leap, cdc_step and calendar_date_counter through scoped names
package cdc_pkg;

  localparam int YEAR_W = 16;

  // reciprocal of 25 for the leap-year check: q = (y * RECIP25) >> RECIP_SH
  // exact for every 16-bit year
  localparam int RECIP_SH = 21;
  localparam int RECIP25  = (2 ** RECIP_SH + 24) / 25;
  localparam int PROD_W   = YEAR_W + 17;
  localparam int QUOT_W   = PROD_W - RECIP_SH;

  localparam logic [1:0] ACT_SET = 2'd0;
  localparam logic [1:0] ACT_INC = 2'd1;
  localparam logic [1:0] ACT_ADD = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
  } date_t;

  // length of a month; codes outside 1..12 read as 31
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] clamp_month(input logic [3:0] month);
    logic [3:0] m;
    if (month > MONTH_DEC) begin
      m = MONTH_DEC;
    end else if (month == 4'd0) begin
      m = MONTH_JAN;
    end else begin
      m = month;
    end
    return m;
  endfunction

  function automatic logic [4:0] clamp_day(input logic [5:0] day, input logic [4:0] lim);
    logic [4:0] d;
    if (day == 6'd0) begin
      d = 5'd1;
    end else if (day > {1'b0, lim}) begin
      d = lim;
    end else begin
      d = day[4:0];
    end
    return d;
  endfunction

endpackage

>>> hdl/cdc_leap.sv
// cdc_leap: two-stage gregorian leap-year check of one year
// depends on cdc_pkg (widths, reciprocal constant)
module cdc_leap (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req,
  input  logic [cdc_pkg::YEAR_W-1:0] year,
  output logic                      done,
  output logic                      leap
);

  logic [cdc_pkg::PROD_W-1:0] prod;
  logic [cdc_pkg::QUOT_W-1:0] q_r;
  logic [cdc_pkg::YEAR_W-1:0] y_r;
  logic                       v1_r;
  logic                       v2_r;
  logic                       leap_r;
  logic [cdc_pkg::YEAR_W:0]   mul25;
  logic                       div25;

  // quotient by 25 through the reciprocal
  assign prod = cdc_pkg::PROD_W'(year) * cdc_pkg::PROD_W'(cdc_pkg::RECIP25);

  // q * 25 as shift-add, then compare back to get divisibility
  assign mul25 = (cdc_pkg::YEAR_W+1)'({q_r, 4'b0000}) + (cdc_pkg::YEAR_W+1)'({q_r, 3'b000})
               + (cdc_pkg::YEAR_W+1)'(q_r);
  assign div25 = ({1'b0, y_r} == mul25);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= prod[cdc_pkg::PROD_W-1:cdc_pkg::RECIP_SH];
    y_r    <= year;
    // divisible by 4, and either not by 100 or also by 400
    leap_r <= (y_r[1:0] == 2'b00) && (!div25 || (y_r[3:0] == 4'b0000));
  end

  assign done = v2_r;
  assign leap = leap_r;

endmodule

>>> hdl/cdc_step.sv
// cdc_step: advances a date by one day given the leap flag of its year
// depends on cdc_pkg (date_t, days_in)
module cdc_step (
  input  cdc_pkg::date_t cur,
  input  logic           leap,
  output cdc_pkg::date_t nxt,
  output logic           year_wrap
);

  logic [5:0] day_inc;
  logic [4:0] lim;

  assign day_inc = {1'b0, cur.day} + 6'd1;
  assign lim     = cdc_pkg::days_in(cur.month, leap);

  always_comb begin
    nxt       = cur;
    year_wrap = 1'b0;
    if (day_inc > {1'b0, lim}) begin
      nxt.day = 5'd1;
      if (cur.month >= cdc_pkg::MONTH_DEC) begin
        nxt.month = cdc_pkg::MONTH_JAN;
        nxt.year  = cur.year + cdc_pkg::YEAR_W'(1);
        year_wrap = 1'b1;
      end else begin
        nxt.month = cur.month + 4'd1;
      end
    end else begin
      nxt.day = day_inc[4:0];
    end
  end

endmodule

>>> hdl/calendar_date_counter.sv
// calendar_date_counter: gregorian day/month/year keeper with set, increment and add
// depends on cdc_pkg, cdc_leap (leap-year unit) and cdc_step (one-day stepper)
//
//  channel | dir | ports                     | contents
//  --------+-----+---------------------------+----------------------------------------
//  in      | in  | in_tvalid/tready/tdata/tuser | one request: action plus date/count
//  out     | out | out_tvalid/tready/tdata    | resulting date, one per request
//
//  from acceptance to out_tvalid: the unused code goes straight to the done state; set
//  waits on the leap-year unit (two stages); increment and add apply the one-day stepper
//  once per cycle, pausing at each new year crossed while the leap unit reruns; every
//  result then passes the done state into the output register
//  reset: date goes to 1 january year 0; output register empty
//  stalls: in_tready is high only while the sequencer is idle; a finished result waits
//  in the output register, and the next request is taken while it does
module calendar_date_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] day_in, [9:6] month_in, [25:10] year_in, [41:26] day_count, [47:42] zero
  input  logic [47:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] day_out, [8:5] month_out, [24:9] year_out, [31:25] zero
  output logic [31:0] out_tdata
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LEAP = 2'd1;  // waiting on the leap-year unit
  localparam logic [1:0] S_STEP = 2'd2;  // one day per cycle
  localparam logic [1:0] S_DONE = 2'd3;  // result ready for the output register

  // request fields
  logic [1:0]                  action;
  logic [5:0]                  day_in;
  logic [3:0]                  month_in;
  logic [cdc_pkg::YEAR_W-1:0]  year_in;
  logic [15:0]                 day_count;

  assign action    = in_tuser;
  assign day_in    = in_tdata[5:0];
  assign month_in  = in_tdata[9:6];
  assign year_in   = in_tdata[25:10];
  assign day_count = in_tdata[41:26];

  logic [1:0]      state_r, state_nxt;
  logic [1:0]      act_r, act_nxt;
  logic [5:0]      din_r, din_nxt;
  logic [15:0]     n_r, n_nxt;
  cdc_pkg::date_t  w_r, w_nxt;          // working date
  logic            wleap_r, wleap_nxt;  // leap flag of the working year
  cdc_pkg::date_t  cur_r, cur_nxt;      // stored date
  logic            cur_leap_r, cur_leap_nxt;
  cdc_pkg::date_t  out_date_r, out_date_nxt;
  logic            out_valid_r, out_valid_nxt;

  // shared units
  logic                       leap_req;
  logic [cdc_pkg::YEAR_W-1:0] leap_year;
  logic                       leap_done;
  logic                       leap_val;
  cdc_pkg::date_t             step_date;
  logic                       step_wrap;

  cdc_leap u_leap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (leap_req),
    .year  (leap_year),
    .done  (leap_done),
    .leap  (leap_val)
  );

  cdc_step u_step (
    .cur       (w_r),
    .leap      (wleap_r),
    .nxt       (step_date),
    .year_wrap (step_wrap)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_date_r.year, out_date_r.month, out_date_r.day};

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    din_nxt       = din_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    wleap_nxt     = wleap_r;
    cur_nxt       = cur_r;
    cur_leap_nxt  = cur_leap_r;
    out_date_nxt  = out_date_r;
    out_valid_nxt = out_valid_r;
    leap_req      = 1'b0;
    leap_year     = year_in;

    // downstream took the held result
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = action;
          din_nxt   = day_in;
          w_nxt     = cur_r;
          wleap_nxt = cur_leap_r;
          n_nxt     = day_count;
          unique case (action)
            cdc_pkg::ACT_SET: begin
              // month is clamped now, day once the leap flag of year_in is known
              w_nxt.month = cdc_pkg::clamp_month(month_in);
              w_nxt.year  = year_in;
              leap_req    = 1'b1;
              leap_year   = year_in;
              state_nxt   = S_LEAP;
            end
            cdc_pkg::ACT_INC: begin
              // increment is an add of one day that commits
              n_nxt     = 16'd1;
              state_nxt = S_STEP;
            end
            cdc_pkg::ACT_ADD: begin
              state_nxt = S_STEP;
            end
            cdc_pkg::ACT_NOP: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LEAP: begin
        if (leap_done) begin
          wleap_nxt = leap_val;
          if (act_r == cdc_pkg::ACT_SET) begin
            w_nxt.day    = cdc_pkg::clamp_day(din_r, cdc_pkg::days_in(w_r.month, leap_val));
            cur_nxt      = w_nxt;
            cur_leap_nxt = leap_val;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (n_r == 16'd0) begin
          if (act_r == cdc_pkg::ACT_INC) begin
            cur_nxt      = w_r;
            cur_leap_nxt = wleap_r;
          end
          state_nxt = S_DONE;
        end else begin
          w_nxt = step_date;
          n_nxt = n_r - 16'd1;
          // new year: refresh the leap flag before the next step
          if (step_wrap) begin
            leap_req  = 1'b1;
            leap_year = step_date.year;
            state_nxt = S_LEAP;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_date_nxt  = w_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= '{year: '0, month: cdc_pkg::MONTH_JAN, day: 5'd1};
      cur_leap_r  <= 1'b1;  // year 0 divides by 400
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      cur_leap_r  <= cur_leap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    din_r      <= din_nxt;
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    wleap_r    <= wleap_nxt;
    out_date_r <= out_date_nxt;
  end

endmodule

>>> hdl/cdc_chk.sv
// cdc_chk: port-level checks on calendar_date_counter, bound to the top level
// depends on calendar_date_counter port names
module cdc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // month field stays within 1..12
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:5] >= 4'd1) && (out_tdata[8:5] <= 4'd12))
    else $error("month out of range");

  // day field never zero
  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] != 5'd0))
    else $error("day of zero");

  // one request at a time: busy right after taking one
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // reset empties the output and leaves the block ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind calendar_date_counter cdc_chk u_cdc_chk (.*);
